### design/email_address_syntax_checker_defines.svh
`ifndef EMAIL_ADDRESS_SYNTAX_CHECKER_DEFINES_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define ESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esc assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define ESC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esc assertion failed");

`endif

### design/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  // Queue between classifier and checker
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes and reset values
  localparam logic REG_LOCAL_MAX  = 1'b0;
  localparam logic REG_DOMAIN_MAX = 1'b1;
  localparam logic [7:0] LOCAL_MAX_RESET  = 8'd64;
  localparam logic [7:0] DOMAIN_MAX_RESET = 8'd63;
  localparam logic [7:0] COUNT_SAT = 8'd255;

  // Character codes
  localparam logic [7:0] CHAR_AT  = 8'h40;
  localparam logic [7:0] CHAR_DOT = 8'h2e;

  // Per-part result codes
  typedef logic [1:0] code_t;
  localparam code_t CODE_OK     = 2'd0;
  localparam code_t CODE_LENGTH = 2'd1;
  localparam code_t CODE_DOT    = 2'd2;
  localparam code_t CODE_CHAR   = 2'd3;

  // Verdict codes
  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_VALID  = 2'd0;
  localparam verdict_t VERDICT_LOCAL  = 2'd1;
  localparam verdict_t VERDICT_DOMAIN = 2'd2;

  // Classified item passed through the queue
  typedef struct packed {
    logic is_dot;
    logic is_at;
    logic local_ok;
    logic domain_ok;
    logic last;
  } byte_class_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c inside {[8'h41:8'h5a]}) ? (c + 8'd32) : c;
  endfunction

  // a-z 0-9 - .
  function automatic logic is_domain_char(input logic [7:0] c);
    is_domain_char = c inside {[8'h61:8'h7a], [8'h30:8'h39], 8'h2d, 8'h2e};
  endfunction

  // domain set plus ! # $ % & ' * + / = ? ^ _ ` { | } ~
  function automatic logic is_local_char(input logic [7:0] c);
    is_local_char = is_domain_char(c) ||
                    (c inside {8'h21, [8'h23:8'h27], 8'h2a, 8'h2b, 8'h2f, 8'h3d,
                               8'h3f, [8'h5e:8'h60], [8'h7b:8'h7e]});
  endfunction

endpackage

### design/esc_front.sv
`timescale 1ns / 1ps

module esc_front import esc_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        is_last,
  input  q_status_t   q_status,
  output logic        push,
  output byte_class_t push_data
);

  logic [7:0] folded;

  // Take an item whenever the queue has room
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // Fold case and classify the byte
  always_comb begin
    folded              = fold_case(char_byte);
    push_data.is_dot    = (folded == CHAR_DOT);
    push_data.is_at     = (folded == CHAR_AT);
    push_data.local_ok  = is_local_char(folded);
    push_data.domain_ok = is_domain_char(folded);
    push_data.last      = is_last;
  end

endmodule

### design/esc_fifo.sv
`timescale 1ns / 1ps
`include "email_address_syntax_checker_defines.svh"

module esc_fifo import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  byte_class_t push_data,
  input  logic        pop,
  output byte_class_t pop_data,
  output q_status_t   q_status
);

  byte_class_t             mem [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;

  assign q_status.full  = (count == QCNT_W'(QDEPTH));
  assign q_status.empty = (count == '0);
  assign pop_data       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ESC_ASSERT_IMP(a_no_overflow, push, !q_status.full)
  `ESC_ASSERT_IMP(a_no_underflow, pop, !q_status.empty)
  `ESC_ASSERT_IMP(a_count_range, 1'b1, count <= QCNT_W'(QDEPTH))

endmodule

### design/esc_back.sv
`timescale 1ns / 1ps
`include "email_address_syntax_checker_defines.svh"

module esc_back import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  q_status_t   q_status,
  input  byte_class_t q_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [1:0]  local_code,
  output logic [1:0]  domain_code
);

  logic [7:0] local_max_length;
  logic [7:0] domain_max_length;

  logic       in_domain,        in_domain_next;
  logic [7:0] local_count,      local_count_next;
  logic [7:0] domain_count,     domain_count_next;
  logic       local_lead_dot,   local_lead_dot_next;
  logic       local_char_err,   local_char_err_next;
  logic       domain_char_err,  domain_char_err_next;
  logic       prev_dot,         prev_dot_next;
  logic       last_domain_dot;
  logic       can_load;
  code_t      lcode, dcode;
  verdict_t   vcode;
  logic       out_codes_ok;
  logic       state_idle;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_max_length  <= LOCAL_MAX_RESET;
      domain_max_length <= DOMAIN_MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOCAL_MAX:  local_max_length  <= cfg_data;
        REG_DOMAIN_MAX: domain_max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pop when an item waits; a final byte also needs a free output slot
  assign can_load = !out_valid || out_ready;
  assign pop      = !q_status.empty && (!q_data.last || can_load);

  // Per-byte state update
  always_comb begin
    in_domain_next       = in_domain;
    local_count_next     = local_count;
    domain_count_next    = domain_count;
    local_lead_dot_next  = local_lead_dot;
    local_char_err_next  = local_char_err;
    domain_char_err_next = domain_char_err;
    prev_dot_next        = prev_dot;
    last_domain_dot      = 1'b0;
    if (!in_domain) begin
      if (q_data.is_at) begin
        in_domain_next = 1'b1;
        prev_dot_next  = 1'b0;
      end else begin
        if (local_count == '0 && q_data.is_dot) local_lead_dot_next = 1'b1;
        if (!q_data.local_ok || (q_data.is_dot && prev_dot)) local_char_err_next = 1'b1;
        prev_dot_next = q_data.is_dot;
        if (local_count != COUNT_SAT) local_count_next = local_count + 1'b1;
      end
    end else begin
      if (!q_data.domain_ok || (q_data.is_dot && prev_dot)) domain_char_err_next = 1'b1;
      prev_dot_next   = q_data.is_dot;
      last_domain_dot = q_data.is_dot;
      if (domain_count != COUNT_SAT) domain_count_next = domain_count + 1'b1;
    end
  end

  // Codes in priority order: length, dot, character
  always_comb begin
    if (local_count_next == '0 || local_count_next > local_max_length) lcode = CODE_LENGTH;
    else if (local_lead_dot_next)  lcode = CODE_DOT;
    else if (local_char_err_next)  lcode = CODE_CHAR;
    else                           lcode = CODE_OK;

    if (domain_count_next == '0 || domain_count_next > domain_max_length) dcode = CODE_LENGTH;
    else if (last_domain_dot)      dcode = CODE_DOT;
    else if (domain_char_err_next) dcode = CODE_CHAR;
    else                           dcode = CODE_OK;

    if (lcode != CODE_OK)      vcode = VERDICT_LOCAL;
    else if (dcode != CODE_OK) vcode = VERDICT_DOMAIN;
    else                       vcode = VERDICT_VALID;
  end

  // Address state; cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || (pop && q_data.last)) begin
      in_domain       <= 1'b0;
      local_count     <= '0;
      domain_count    <= '0;
      local_lead_dot  <= 1'b0;
      local_char_err  <= 1'b0;
      domain_char_err <= 1'b0;
      prev_dot        <= 1'b0;
    end else if (pop) begin
      in_domain       <= in_domain_next;
      local_count     <= local_count_next;
      domain_count    <= domain_count_next;
      local_lead_dot  <= local_lead_dot_next;
      local_char_err  <= local_char_err_next;
      domain_char_err <= domain_char_err_next;
      prev_dot        <= prev_dot_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_data.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      verdict     <= vcode;
      local_code  <= lcode;
      domain_code <= dcode;
    end
  end

  // Terms for the checks below
  assign out_codes_ok = (local_code == CODE_OK) && (domain_code == CODE_OK);
  assign state_idle   = !in_domain && (local_count == '0);

  `ESC_ASSERT_IMP(a_verdict_ok, out_valid, (verdict == VERDICT_VALID) == out_codes_ok)
  `ESC_ASSERT_IMP(a_verdict_local, out_valid && (local_code != CODE_OK), verdict == VERDICT_LOCAL)
  `ESC_ASSERT_NXT(a_result_loaded, pop && q_data.last, out_valid && state_idle)

endmodule

### design/email_address_syntax_checker.sv
`timescale 1ns / 1ps
// Email address syntax checker.
// Input channel (in_valid/in_ready): one address byte per item in char_byte,
// with is_last high on the final byte. Bytes before the first '@' are the
// local part, everything after it is the domain.
// Output channel (out_valid/out_ready): one result per address, carrying
// verdict, local_code and domain_code, issued for the final byte only.
// Configuration: cfg_write with cfg_index 0 sets the local part maximum
// length, index 1 the domain maximum; write only while the block is idle.
// Throughput: one byte per cycle while the queue has room, set by the
// combinational classifier and the state update behind a four-entry queue.
// Result path: an accepted final byte is first written into the queue, then
// popped, and its result is loaded into the output register.
// Receiver stall: the output register holds the result; bytes keep flowing
// into the checker until the next final byte, then the queue fills and
// in_ready drops.
// Reset: clears the queue, the address state and out_valid, and restores
// maximum lengths of 64 and 63.

module email_address_syntax_checker import esc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] verdict,
  output logic [1:0] local_code,
  output logic [1:0] domain_code
);

  q_status_t   q_status;
  logic        push;
  logic        pop;
  byte_class_t push_data;
  byte_class_t pop_data;

  // Classifier
  esc_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_byte (char_byte),
    .is_last   (is_last),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Queue between classifier and checker
  esc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // Checker and result register
  esc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict),
    .local_code  (local_code),
    .domain_code (domain_code)
  );

endmodule
